/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, held off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/rckt_pkg.sv */
// Constants and types for the reference-counted key table.
`default_nettype none

package rckt_pkg;

   // table geometry
   localparam int SLOTS     = 16;
   localparam int KEY_BITS  = 64;
   localparam int REF_BITS  = 16;
   localparam int ID_BITS   = 32;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int CNT_BITS  = $clog2(SLOTS + 1);

   // port field widths
   localparam int OP_W     = 2;
   localparam int KEY_W    = 64;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int ID_W     = 32;
   localparam int REFC_W   = 16;
   localparam int USED_W   = 5;

   // request opcodes
   localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FREED    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;
   localparam logic [STATUS_W-1:0] ST_COUNT    = 3'd6;

   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

   // one slot as held in the slot memory
   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [REF_BITS-1:0] refs;
      logic [ID_BITS-1:0]  id;
   } slot_entry_type;

   // write port of the slot memory
   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] addr;
      slot_entry_type       data;
   } slot_write_type;

endpackage

`default_nettype wire

/* sv/refcounted_key_table_top.sv */
// Reference-counted key table: top level with scan sequencer and slot state.
//
// Usage:
//   Request channel: drive req_op and req_key with start high; the request is
//   taken at a rising edge where start is high and busy is low.
//   Response channel: rsp_strobe is high for exactly one cycle with the
//   response fields; the receiver cannot stall it.
// Request handling:
//   A query is answered in the cycle after it is taken; busy stays low, so a
//   query can be taken every cycle.
//   An acquire or release scans the slot memory slot by slot, with a read
//   state and then a compare state per slot, lowest slot first. A hit ends
//   the scan early; a miss scans every slot. The next request can be taken
//   in the cycle the response is shown. The read-then-compare step per slot
//   comes from the single registered read port of the slot memory.
// Reset:
//   Synchronous, active high. All slots are free, the used count is zero and
//   the id counter restarts at one. No clearing pass is needed: per-slot used
//   flags are cleared at once.
`default_nettype none

module refcounted_key_table_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic [rckt_pkg::OP_W-1:0]     req_op,
   input  wire logic [rckt_pkg::KEY_W-1:0]    req_key,
   output      logic                          rsp_strobe,
   output      logic [rckt_pkg::STATUS_W-1:0] rsp_status,
   output      logic [rckt_pkg::SLOT_W-1:0]   rsp_slot,
   output      logic [rckt_pkg::ID_W-1:0]     rsp_entry_id,
   output      logic [rckt_pkg::REFC_W-1:0]   rsp_ref_count,
   output      logic [rckt_pkg::USED_W-1:0]   rsp_used_count
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_CMP  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [rckt_pkg::OP_W-1:0]      op_ff, op_in;
   logic [rckt_pkg::KEY_BITS-1:0]  key_ff, key_in;
   logic [rckt_pkg::SLOT_BITS-1:0] idx_ff, idx_in;
   logic [rckt_pkg::SLOT_BITS-1:0] free_ff, free_in;
   logic                           free_found_ff, free_found_in;
   logic [rckt_pkg::SLOTS-1:0]     used_ff, used_in;
   logic [rckt_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic [rckt_pkg::ID_BITS-1:0]   next_id_ff, next_id_in;

   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [rckt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [rckt_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [rckt_pkg::ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [rckt_pkg::REFC_W-1:0]   rsp_refs_ff, rsp_refs_in;
   logic [rckt_pkg::USED_W-1:0]   rsp_used_ff, rsp_used_in;

   logic                          rd_en;
   rckt_pkg::slot_entry_type      rd_data;
   rckt_pkg::slot_write_type      wr;
   logic                          hit;
   logic [rckt_pkg::REF_BITS-1:0] refs_up;
   logic [rckt_pkg::REF_BITS-1:0] refs_down;
   logic                          last_slot;

   // slot memory
   rckt_store u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data),
      .wr      (wr)
   );

   // compare and count arithmetic on the slot just read
   assign hit       = used_ff[idx_ff] && (rd_data.key == key_ff);
   assign refs_up   = (rd_data.refs == rckt_pkg::REF_MAX) ? rd_data.refs
                                                          : rd_data.refs + 1'b1;
   assign refs_down = rd_data.refs - 1'b1;
   assign last_slot = (idx_ff == rckt_pkg::SLOT_BITS'(rckt_pkg::SLOTS - 1));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      used_in       = used_ff;
      count_in      = count_ff;
      next_id_in    = next_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_refs_in   = rsp_refs_ff;
      rd_en         = 1'b0;
      wr            = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_op;
               key_in = req_key[rckt_pkg::KEY_BITS-1:0];
               if (req_op inside {rckt_pkg::OP_ACQUIRE, rckt_pkg::OP_RELEASE}) begin
                  idx_in        = '0;
                  free_found_in = 1'b0;
                  state_in      = S_READ;
               end else begin
                  // query, and the spare opcode with it
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = rckt_pkg::ST_COUNT;
                  rsp_slot_in   = '0;
                  rsp_id_in     = '0;
                  rsp_refs_in   = '0;
               end
            end
         end

         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CMP;
         end

         S_CMP: begin
            if (hit) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_slot_in   = rckt_pkg::SLOT_W'(idx_ff);
               wr.addr       = idx_ff;
               wr.data.key   = key_ff;
               wr.data.id    = rd_data.id;
               if (op_ff == rckt_pkg::OP_ACQUIRE) begin
                  wr.en         = 1'b1;
                  wr.data.refs  = refs_up;
                  rsp_status_in = rckt_pkg::ST_HIT;
                  rsp_id_in     = rckt_pkg::ID_W'(rd_data.id);
                  rsp_refs_in   = rckt_pkg::REFC_W'(refs_up);
               end else if (rd_data.refs <= rckt_pkg::REF_BITS'(1)) begin
                  // last reference gone: free the slot
                  used_in[idx_ff] = 1'b0;
                  count_in        = count_ff - 1'b1;
                  rsp_status_in   = rckt_pkg::ST_FREED;
                  rsp_id_in       = '0;
                  rsp_refs_in     = '0;
               end else begin
                  wr.en         = 1'b1;
                  wr.data.refs  = refs_down;
                  rsp_status_in = rckt_pkg::ST_RELEASED;
                  rsp_id_in     = '0;
                  rsp_refs_in   = rckt_pkg::REFC_W'(refs_down);
               end
            end else begin
               // remember the lowest free slot on the way
               if (!used_ff[idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = idx_ff;
               end
               if (last_slot) begin
                  state_in      = S_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_slot_in   = '0;
                  rsp_id_in     = '0;
                  rsp_refs_in   = '0;
                  if (op_ff != rckt_pkg::OP_ACQUIRE) begin
                     rsp_status_in = rckt_pkg::ST_NOTFOUND;
                  end else if (free_found_in) begin
                     // allocate with a fresh id; zero is skipped on wrap
                     used_in[free_in] = 1'b1;
                     count_in         = count_ff + 1'b1;
                     next_id_in       = next_id_ff + 1'b1;
                     if (next_id_in == '0) begin
                        next_id_in = rckt_pkg::ID_BITS'(1);
                     end
                     wr.en         = 1'b1;
                     wr.addr       = free_in;
                     wr.data.key   = key_ff;
                     wr.data.refs  = rckt_pkg::REF_BITS'(1);
                     wr.data.id    = next_id_ff;
                     rsp_status_in = rckt_pkg::ST_ALLOC;
                     rsp_slot_in   = rckt_pkg::SLOT_W'(free_in);
                     rsp_id_in     = rckt_pkg::ID_W'(next_id_ff);
                     rsp_refs_in   = rckt_pkg::REFC_W'(1);
                  end else begin
                     rsp_status_in = rckt_pkg::ST_FULL;
                  end
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_used_in = rsp_strobe_in ? rckt_pkg::USED_W'(count_in) : rsp_used_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         count_ff      <= '0;
         next_id_ff    <= rckt_pkg::ID_BITS'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         count_ff      <= count_in;
         next_id_ff    <= next_id_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      free_ff       <= free_in;
      free_found_ff <= free_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_refs_ff   <= rsp_refs_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_entry_id   = rsp_id_ff;
   assign rsp_ref_count  = rsp_refs_ff;
   assign rsp_used_count = rsp_used_ff;

endmodule

`default_nettype wire

/* sv/rckt_store.sv */
// Slot memory: key, count and id per slot, one write and one registered read port.
`default_nettype none

module rckt_store (
   input  wire logic                           clock,
   input  wire logic                           rd_en,
   input  wire logic [rckt_pkg::SLOT_BITS-1:0] rd_addr,
   output rckt_pkg::slot_entry_type            rd_data,
   input  wire rckt_pkg::slot_write_type       wr
);

   rckt_pkg::slot_entry_type mem [rckt_pkg::SLOTS];
   rckt_pkg::slot_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/rckt_checker.sv */
// Port-level checks on the key table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rckt_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic [rckt_pkg::OP_W-1:0]     req_op,
   input wire logic                          rsp_strobe,
   input wire logic [rckt_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [rckt_pkg::ID_W-1:0]     rsp_entry_id,
   input wire logic [rckt_pkg::REFC_W-1:0]   rsp_ref_count,
   input wire logic [rckt_pkg::USED_W-1:0]   rsp_used_count
);

   // a query is answered in the very next cycle
   `ASSERT_NEXT(a_query_next, clock, reset, start && !busy && req_op[1], rsp_strobe && (rsp_status == rckt_pkg::ST_COUNT))

   // an acquire or release holds the channel while the table is scanned
   `ASSERT_NEXT(a_scan_busy, clock, reset, start && !busy && !req_op[1], busy && !rsp_strobe)

   // full is only reported when every slot is in use
   `ASSERT_IMPLIES(a_full_count, clock, reset, rsp_strobe && (rsp_status == rckt_pkg::ST_FULL), rsp_used_count == rckt_pkg::USED_W'(rckt_pkg::SLOTS))

   // an allocation always carries a non-zero id and a count of one
   `ASSERT_IMPLIES(a_alloc_fields, clock, reset, rsp_strobe && (rsp_status == rckt_pkg::ST_ALLOC), (rsp_entry_id != '0) && (rsp_ref_count == rckt_pkg::REFC_W'(1)))

endmodule

bind refcounted_key_table_top rckt_checker u_rckt_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the reference-counted key table.
`timescale 1ns / 1ps

module tb;
   import rckt_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int KEY_POOL       = 24;
   localparam int RANDOM_PHASES  = 4;
   localparam int PHASE_ITEMS    = 425;

   // op code 3 is not decoded by the block and must behave as a query
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [ID_W-1:0]     entry_id;
      logic [REFC_W-1:0]   ref_count;
      logic [USED_W-1:0]   used_count;
   } table_response_type;

   // Shadow copy of the slot table plus the queue of responses it predicts
   class key_table_ledger;
      bit                  slot_used [SLOTS];
      logic [KEY_W-1:0]    slot_key  [SLOTS];
      logic [REF_BITS-1:0] slot_refs [SLOTS];
      logic [ID_BITS-1:0]  slot_id   [SLOTS];
      int unsigned         entry_count;
      logic [ID_BITS-1:0]  next_id;
      table_response_type  expected_q [$];
      int                  mismatches;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_refs[i] = '0;
            slot_id[i]   = '0;
         end
         entry_count = 0;
         next_id     = ID_BITS'(1);
         mismatches  = 0;
      endfunction

      function int pending_count();
         return expected_q.size();
      endfunction

      function int find_slot(logic [KEY_W-1:0] key);
         for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_key[i] == key)
               return i;
         return -1;
      endfunction

      function void push_response(logic [STATUS_W-1:0] status, int slot,
                                  logic [ID_W-1:0] entry_id, logic [REFC_W-1:0] ref_count);
         table_response_type r;
         r.status     = status;
         r.slot       = SLOT_W'(slot);
         r.entry_id   = entry_id;
         r.ref_count  = ref_count;
         r.used_count = USED_W'(entry_count);
         expected_q.push_back(r);
      endfunction

      // Apply one accepted request to the shadow table and queue its response
      function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] raw_key);
         logic [KEY_W-1:0] key_mask;
         logic [KEY_W-1:0] key;
         int               hit;
         key_mask = (KEY_BITS >= 64) ? {KEY_W{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);
         key      = raw_key & key_mask;
         hit      = find_slot(key);
         if (op == OP_ACQUIRE) begin
            if (hit >= 0) begin
               // count sticks at its maximum but still reports a hit
               if (slot_refs[hit] != REF_MAX)
                  slot_refs[hit]++;
               push_response(ST_HIT, hit, slot_id[hit], slot_refs[hit]);
               return;
            end
            if (entry_count < SLOTS) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!slot_used[i]) begin
                     slot_used[i] = 1'b1;
                     slot_key[i]  = key;
                     slot_refs[i] = REF_BITS'(1);
                     slot_id[i]   = next_id;
                     // id counter skips zero on wrap
                     next_id++;
                     if (next_id == 0)
                        next_id = ID_BITS'(1);
                     entry_count++;
                     push_response(ST_ALLOC, i, slot_id[i], slot_refs[i]);
                     return;
                  end
               end
            end
            push_response(ST_FULL, 0, '0, '0);
         end else if (op == OP_RELEASE) begin
            if (hit < 0) begin
               push_response(ST_NOTFOUND, 0, '0, '0);
               return;
            end
            if (slot_refs[hit] > 0)
               slot_refs[hit]--;
            if (slot_refs[hit] == 0) begin
               slot_used[hit] = 1'b0;
               slot_key[hit]  = '0;
               slot_id[hit]   = '0;
               if (entry_count > 0)
                  entry_count--;
               push_response(ST_FREED, hit, '0, '0);
            end else begin
               push_response(ST_RELEASED, hit, '0, slot_refs[hit]);
            end
         end else begin
            push_response(ST_COUNT, 0, '0, '0);
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      // Compare one response with the oldest prediction
      task check_response(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                          logic [ID_W-1:0] entry_id, logic [REFC_W-1:0] ref_count,
                          logic [USED_W-1:0] used_count);
         table_response_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response, status %0d", status));
            return;
         end
         want = expected_q.pop_front();
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
         if (slot !== want.slot)
            report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
         if (entry_id !== want.entry_id)
            report_mismatch($sformatf("entry_id %0h, want %0h", entry_id, want.entry_id));
         if (ref_count !== want.ref_count)
            report_mismatch($sformatf("ref_count %0d, want %0d", ref_count, want.ref_count));
         if (used_count !== want.used_count)
            report_mismatch($sformatf("used_count %0d, want %0d", used_count, want.used_count));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_op = '0;
   logic [KEY_W-1:0]    req_key = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [ID_W-1:0]     rsp_entry_id;
   logic [REFC_W-1:0]   rsp_ref_count;
   logic [USED_W-1:0]   rsp_used_count;

   key_table_ledger  ledger = new();
   logic [KEY_W-1:0] key_pool [KEY_POOL];
   int               idle_cycles = 0;

   refcounted_key_table_top DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_key        (req_key),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_entry_id   (rsp_entry_id),
      .rsp_ref_count  (rsp_ref_count),
      .rsp_used_count (rsp_used_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Observe both channels at each edge; also the stall watchdog
   always @(posedge clock) begin
      if (!reset && start && !busy)
         ledger.note_request(req_op, req_key);
      if (!reset && rsp_strobe)
         ledger.check_response(rsp_status, rsp_slot, rsp_entry_id, rsp_ref_count,
                               rsp_used_count);
      if (!reset && ((start && !busy) || rsp_strobe))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Present one request, hold it until taken, then idle for the given gap
   task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, int gap);
      req_op  <= op;
      req_key <= key;
      start   <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait for every outstanding response
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (ledger.pending_count() != 0)
         @(posedge clock);
   endtask

   // Mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(bit bursty);
      int r;
      r = $urandom_range(0, 99);
      if (bursty || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [OP_W-1:0] pick_op(int acquire_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < acquire_pct)
         return OP_ACQUIRE;
      if (r < 90)
         return OP_RELEASE;
      if (r < 98)
         return OP_QUERY;
      return OP_UNUSED;
   endfunction

   // Mostly keys from the working set, now and then a stranger
   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 6)
         return {$urandom, $urandom};
      return key_pool[$urandom_range(0, KEY_POOL - 1)];
   endfunction

   initial begin
      bit bursty;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++)
         key_pool[i] = {$urandom, $urandom};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: queries on an empty table, the undecoded op, release of an
      // absent key, a full acquire/release round trip, then fill to overflow
      send_request(OP_QUERY, '0, 0);
      send_request(OP_UNUSED, '1, 1);
      send_request(OP_RELEASE, key_pool[0], 0);
      send_request(OP_ACQUIRE, key_pool[0], 0);
      send_request(OP_ACQUIRE, key_pool[0], 2);
      send_request(OP_RELEASE, key_pool[0], 0);
      send_request(OP_RELEASE, key_pool[0], 0);
      for (int i = 0; i < SLOTS; i++)
         send_request(OP_ACQUIRE, key_pool[i], pick_gap(1'b0));
      send_request(OP_ACQUIRE, key_pool[SLOTS], 0);
      send_request(OP_QUERY, '0, 0);
      wait_drained();

      // Random traffic, alternating acquire-heavy and release-heavy phases
      bursty = 1'b0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 50 == 0)
               bursty = ($urandom_range(0, 3) == 0);
            send_request(pick_op((p % 2 == 0) ? 60 : 30), pick_key(), pick_gap(bursty));
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending_count() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/rckt_pkg.sv
sv/rckt_store.sv
sv/refcounted_key_table_top.sv
sv/rckt_checker.sv
tb/tb.sv
